// ===== rtl/hvl_pkg.sv =====
package hvl_pkg;

  localparam int MaxTilesSideDef = 64;
  localparam int GammaEntriesDef = 1024;

  localparam int ElevW    = 12;
  localparam int CoordW   = 7;
  localparam int LevelW   = 15;
  localparam int ShadeW   = 8;
  localparam int FracBits = 14;

  // normalizer widths
  localparam int NIW       = 22;          // raw vector component, signed
  localparam int SQW       = 46;          // sum of squares, even
  localparam int RootSteps = SQW / 2;
  localparam int LW        = 23;          // vector length
  localparam int DW        = 37;          // divider remainder
  localparam int DivSteps  = 15;          // quotient bits
  localparam int NW        = 16;          // Q1.14 component, signed
  localparam int SumW      = 18;          // sum of four normals
  localparam int DotW      = 34;
  localparam int LamW      = 17;

  localparam logic [ShadeW-1:0] ShadeMax = 8'd255;
  localparam logic [DotW-1:0]   RoundHalf = DotW'(1 << (FracBits - 1));

  localparam logic [CoordW-1:0] RstTilesWide = 7'd64;
  localparam logic [CoordW-1:0] RstTilesHigh = 7'd64;
  localparam logic [LevelW-1:0] RstLightX    = 15'sd4915;
  localparam logic [LevelW-1:0] RstLightY    = -15'sd9830;
  localparam logic [LevelW-1:0] RstLightZ    = -15'sd13844;
  localparam logic [LevelW-1:0] RstSun       = 15'd16384;
  localparam logic [LevelW-1:0] RstAmbient   = 15'd819;

  typedef enum logic [2:0] {
    CFG_TILES_WIDE,
    CFG_TILES_HIGH,
    CFG_LIGHT_X,
    CFG_LIGHT_Y,
    CFG_LIGHT_Z,
    CFG_SUN,
    CFG_AMBIENT
  } hvl_cfg_idx_e;

  typedef enum logic [1:0] {
    SRC_CORNER,
    SRC_SUM,
    SRC_LIGHT
  } hvl_src_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_RAW,
    ST_NORM_C,
    ST_SUM,
    ST_NORM_S,
    ST_LIGHT,
    ST_NORM_L,
    ST_DOT,
    ST_LIN,
    ST_GAMMA,
    ST_LOOKUP,
    ST_FINISH
  } hvl_state_e;

  typedef enum logic [2:0] {
    N_IDLE,
    N_SQ,
    N_ROOT,
    N_DIVI,
    N_DIV
  } hvl_nstate_e;

  typedef logic [2:0][NIW-1:0] hvl_raw_t;
  typedef logic [2:0][NW-1:0]  hvl_nrm_t;

  typedef struct packed {
    logic       accept;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       cap_en;
    logic [1:0] cap_sel;
    logic [1:0] corner;
    logic       norm_start;
    hvl_src_e   norm_src;
    logic       sum_add;
    logic       nrm_keep;
    logic       dot_en;
    logic [1:0] dot_sel;
    logic       lin_en;
    logic       gamma_en;
    logic       look_en;
    logic       out_load;
  } hvl_cmd_t;

  typedef struct packed {
    logic is_shade;
    logic outside;
    logic centre;
    logic norm_done;
    logic out_busy;
  } hvl_status_t;

  // largest s with (s/255)^2.2 <= k/n, exact integer compare
  function automatic logic [7:0] gamma_entry(input int unsigned k, input int unsigned n);
    logic [159:0] rhs;
    logic [159:0] lhs;
    logic [7:0]   s;
    logic [7:0]   t;
    rhs = 160'd1;
    for (int i = 0; i < 5; i++) rhs = rhs * 160'(k);
    for (int i = 0; i < 11; i++) rhs = rhs * 160'd255;
    s = '0;
    for (int b = 7; b >= 0; b--) begin
      t = s | 8'(1 << b);
      lhs = 160'd1;
      for (int i = 0; i < 11; i++) lhs = lhs * 160'(t);
      for (int i = 0; i < 5; i++) lhs = lhs * 160'(n);
      if (lhs <= rhs) s = t;
    end
    return s;
  endfunction

endpackage

// ===== rtl/hvl_ram.sv =====
module hvl_ram import hvl_pkg::*; #(
  parameter int Width = ElevW,
  parameter int Depth = 4225
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/hvl_norm.sv =====
module hvl_norm import hvl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  hvl_raw_t vec_i,
  output hvl_nrm_t nrm_o,
  output logic     done_o
);

  localparam int CntW = $clog2(RootSteps);

  hvl_nstate_e state_q, state_d;
  hvl_raw_t    v_q, v_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [1:0]  c_q, c_d;
  logic [SQW-1:0] sq_q, sq_d, rt_q, rt_d, bit_q, bit_d;
  logic [DW-1:0]  rem_q, rem_d, dsh_q, dsh_d;
  logic [DivSteps-1:0] quo_q, quo_d;
  hvl_nrm_t    n_q, n_d;
  logic        done_q, done_d;

  logic [NIW-1:0]   cur;
  logic [NIW-1:0]   mag;
  logic [2*NIW-1:0] sqr;
  logic [SQW-1:0]   trial;
  logic [LW-1:0]    len;
  logic [NW-1:0]    qn;
  logic             ge;

  assign cur   = v_q[c_q];
  assign mag   = cur[NIW-1] ? NIW'(0) - cur : cur;
  assign sqr   = mag * mag;
  assign trial = rt_q + bit_q;
  assign len   = rt_q[LW-1:0];
  assign ge    = rem_q >= dsh_q;

  always_comb begin
    state_d = state_q;
    v_d     = v_q;
    cnt_d   = cnt_q;
    c_d     = c_q;
    sq_d    = sq_q;
    rt_d    = rt_q;
    bit_d   = bit_q;
    rem_d   = rem_q;
    dsh_d   = dsh_q;
    quo_d   = quo_q;
    n_d     = n_q;
    done_d  = 1'b0;
    qn      = '0;
    unique case (state_q)
      N_IDLE: begin
        if (start_i) begin
          v_d     = vec_i;
          c_d     = '0;
          sq_d    = '0;
          state_d = N_SQ;
        end
      end
      N_SQ: begin
        sq_d = sq_q + SQW'(sqr);
        c_d  = c_q + 2'd1;
        if (c_q == 2'd2) begin
          rt_d    = '0;
          bit_d   = SQW'(1) << (SQW - 2);
          cnt_d   = '0;
          state_d = N_ROOT;
        end
      end
      N_ROOT: begin
        if (sq_q >= trial) begin
          sq_d = sq_q - trial;
          rt_d = (rt_q >> 1) + bit_q;
        end else begin
          rt_d = rt_q >> 1;
        end
        bit_d = bit_q >> 2;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(RootSteps - 1)) begin
          c_d     = '0;
          state_d = N_DIVI;
        end
      end
      N_DIVI: begin
        rem_d   = (DW'(mag) << FracBits) + DW'(len >> 1);
        dsh_d   = DW'(len) << FracBits;
        quo_d   = '0;
        cnt_d   = '0;
        state_d = N_DIV;
      end
      N_DIV: begin
        if (ge) begin
          rem_d = rem_q - dsh_q;
        end
        quo_d = {quo_q[DivSteps-2:0], ge};
        dsh_d = dsh_q >> 1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(DivSteps - 1)) begin
          qn = NW'(quo_d);
          if (len == '0) begin
            n_d[c_q] = '0;
          end else begin
            n_d[c_q] = cur[NIW-1] ? NW'(0) - qn : qn;
          end
          if (c_q == 2'd2) begin
            done_d  = 1'b1;
            state_d = N_IDLE;
          end else begin
            c_d     = c_q + 2'd1;
            state_d = N_DIVI;
          end
        end
      end
      default: state_d = N_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= N_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
      c_q     <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
      c_q     <= c_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    sq_q  <= sq_d;
    rt_q  <= rt_d;
    bit_q <= bit_d;
    rem_q <= rem_d;
    dsh_q <= dsh_d;
    quo_q <= quo_d;
    n_q   <= n_d;
  end

  assign nrm_o  = n_q;
  assign done_o = done_q;

endmodule

// ===== rtl/hvl_ctrl.sv =====
module hvl_ctrl import hvl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  hvl_status_t st_i,
  output hvl_cmd_t    cmd_o
);

  hvl_state_e state_q, state_d;
  logic [1:0] k_q, k_d;
  logic [2:0] rd_q, rd_d;
  logic [1:0] d_q, d_d;

  always_comb begin
    state_d    = state_q;
    k_d        = k_q;
    rd_d       = rd_q;
    d_d        = d_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.norm_src = SRC_CORNER;
    cmd_o.corner   = k_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          k_d  = '0;
          rd_d = '0;
          if (st_i.is_shade) begin
            state_d = st_i.outside ? ST_FINISH : ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd_o.rd_en   = ~rd_q[2];
        cmd_o.rd_sel  = rd_q[1:0];
        cmd_o.cap_en  = rd_q != 3'd0;
        cmd_o.cap_sel = rd_q[1:0] - 2'd1;
        rd_d = rd_q + 3'd1;
        if (rd_q[2]) state_d = ST_RAW;
      end
      ST_RAW: begin
        cmd_o.norm_start = 1'b1;
        state_d = ST_NORM_C;
      end
      ST_NORM_C: begin
        if (st_i.norm_done) begin
          if (st_i.centre) begin
            cmd_o.sum_add = 1'b1;
            if (k_q == 2'd3) begin
              state_d = ST_SUM;
            end else begin
              k_d     = k_q + 2'd1;
              rd_d    = '0;
              state_d = ST_READ;
            end
          end else begin
            cmd_o.nrm_keep = 1'b1;
            state_d = ST_LIGHT;
          end
        end
      end
      ST_SUM: begin
        cmd_o.norm_start = 1'b1;
        cmd_o.norm_src   = SRC_SUM;
        state_d = ST_NORM_S;
      end
      ST_NORM_S: begin
        if (st_i.norm_done) begin
          cmd_o.nrm_keep = 1'b1;
          state_d = ST_LIGHT;
        end
      end
      ST_LIGHT: begin
        cmd_o.norm_start = 1'b1;
        cmd_o.norm_src   = SRC_LIGHT;
        state_d = ST_NORM_L;
      end
      ST_NORM_L: begin
        if (st_i.norm_done) begin
          d_d     = '0;
          state_d = ST_DOT;
        end
      end
      ST_DOT: begin
        cmd_o.dot_en  = 1'b1;
        cmd_o.dot_sel = d_q;
        d_d = d_q + 2'd1;
        if (d_q == 2'd2) state_d = ST_LIN;
      end
      ST_LIN: begin
        cmd_o.lin_en = 1'b1;
        state_d = ST_GAMMA;
      end
      ST_GAMMA: begin
        cmd_o.gamma_en = 1'b1;
        state_d = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        cmd_o.look_en = 1'b1;
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!st_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
      rd_q    <= '0;
      d_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      rd_q    <= rd_d;
      d_q     <= d_d;
    end
  end

endmodule

// ===== rtl/hvl_dp.sv =====
module hvl_dp import hvl_pkg::*; #(
  parameter int MaxTilesSide = MaxTilesSideDef,
  parameter int GammaEntries = GammaEntriesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hvl_cmd_t          cmd_i,
  output hvl_status_t       st_o,
  input  logic [31:0]       in_data_i,
  input  logic [1:0]        in_user_i,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [LevelW-1:0] cfg_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ShadeW-1:0] out_shade_o,
  output logic              out_flag_o
);

  localparam int GridSide = MaxTilesSide + 1;
  localparam int Depth    = GridSide * GridSide;
  localparam int AW       = $clog2(Depth);
  localparam int XW       = ($clog2(GridSide) > CoordW) ? $clog2(GridSide) : CoordW;
  localparam int GIW      = $clog2(GammaEntries);
  localparam int SclW     = FracBits + $clog2(GammaEntries + 1);

  // configuration
  logic [CoordW-1:0] tw_q, th_q;
  logic [LevelW-1:0] lx_q, ly_q, lz_q, sun_q, amb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tw_q  <= RstTilesWide;
      th_q  <= RstTilesHigh;
      lx_q  <= RstLightX;
      ly_q  <= RstLightY;
      lz_q  <= RstLightZ;
      sun_q <= RstSun;
      amb_q <= RstAmbient;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TILES_WIDE: tw_q  <= cfg_data_i[CoordW-1:0];
        CFG_TILES_HIGH: th_q  <= cfg_data_i[CoordW-1:0];
        CFG_LIGHT_X:    lx_q  <= cfg_data_i;
        CFG_LIGHT_Y:    ly_q  <= cfg_data_i;
        CFG_LIGHT_Z:    lz_q  <= cfg_data_i;
        CFG_SUN:        sun_q <= cfg_data_i;
        CFG_AMBIENT:    amb_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [XW-1:0] w, h;
  assign w = (tw_q == '0) ? XW'(1) :
             ((XW'(tw_q) > XW'(MaxTilesSide)) ? XW'(MaxTilesSide) : XW'(tw_q));
  assign h = (th_q == '0) ? XW'(1) :
             ((XW'(th_q) > XW'(MaxTilesSide)) ? XW'(MaxTilesSide) : XW'(th_q));

  // input item
  logic              in_op, in_ctr;
  logic [XW-1:0]     in_col, in_row;
  logic [ElevW-1:0]  in_elev;
  logic              in_grid, wr_en;
  logic [AW-1:0]     waddr;

  assign in_op   = in_user_i[0];
  assign in_ctr  = in_user_i[1];
  assign in_col  = XW'(in_data_i[CoordW-1:0]);
  assign in_row  = XW'(in_data_i[2*CoordW-1:CoordW]);
  assign in_elev = in_data_i[2*CoordW +: ElevW];
  assign in_grid = (in_col <= w) && (in_row <= h);
  assign wr_en   = cmd_i.accept && !in_op && in_grid;
  assign waddr   = AW'(in_row) * AW'(GridSide) + AW'(in_col);

  logic [XW-1:0] xq_q, yq_q;
  logic          centre_q, outside_q, outside;

  assign outside = in_ctr ? (in_col >= w || in_row >= h) : (in_col > w || in_row > h);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      xq_q      <= in_col;
      yq_q      <= in_row;
      centre_q  <= in_ctr;
      outside_q <= outside;
    end
  end

  // corner neighborhood
  logic [XW-1:0] cx, cy, xl, xr, yl, yr, rx, ry;
  logic          a2, b2;
  logic [AW-1:0] raddr;
  logic [ElevW-1:0] rdata;
  logic [ElevW-1:0] elev_q [4];

  assign cx = xq_q + XW'(cmd_i.corner == 2'd1 || cmd_i.corner == 2'd2);
  assign cy = yq_q + XW'(cmd_i.corner[1]);
  assign xl = (cx == '0) ? '0 : cx - XW'(1);
  assign xr = (cx < w) ? cx + XW'(1) : w;
  assign yl = (cy == '0) ? '0 : cy - XW'(1);
  assign yr = (cy < h) ? cy + XW'(1) : h;
  assign b2 = (cx != '0) && (cx < w);
  assign a2 = (cy != '0) && (cy < h);

  always_comb begin
    unique case (cmd_i.rd_sel)
      2'd0:    begin rx = xl; ry = cy; end
      2'd1:    begin rx = xr; ry = cy; end
      2'd2:    begin rx = cx; ry = yl; end
      default: begin rx = cx; ry = yr; end
    endcase
  end

  assign raddr = AW'(ry) * AW'(GridSide) + AW'(rx);

  hvl_ram #(
    .Width (ElevW),
    .Depth (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (waddr),
    .wdata_i (in_elev),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_en) begin
      elev_q[cmd_i.cap_sel] <= rdata;
    end
  end

  // raw vectors
  logic [ElevW:0] dzx, dzy;
  logic [NIW-1:0] dzx_x, dzy_x;
  hvl_raw_t       raw_c, raw_s, raw_l, vin;
  logic [SumW-1:0] sum_q [3];
  logic [LevelW:0] lneg [3];

  assign dzx   = {1'b0, elev_q[0]} - {1'b0, elev_q[1]};
  assign dzy   = {1'b0, elev_q[2]} - {1'b0, elev_q[3]};
  assign dzx_x = {{(NIW-ElevW-1){dzx[ElevW]}}, dzx};
  assign dzy_x = {{(NIW-ElevW-1){dzy[ElevW]}}, dzy};

  assign raw_c[0] = a2 ? dzx_x << 9 : dzx_x << 8;
  assign raw_c[1] = b2 ? dzy_x << 9 : dzy_x << 8;
  assign raw_c[2] = (a2 && b2) ? NIW'(1) << 18 : ((a2 || b2) ? NIW'(1) << 17 : NIW'(1) << 16);

  assign lneg[0] = (LevelW+1)'(0) - {lx_q[LevelW-1], lx_q};
  assign lneg[1] = (LevelW+1)'(0) - {ly_q[LevelW-1], ly_q};
  assign lneg[2] = (LevelW+1)'(0) - {lz_q[LevelW-1], lz_q};

  for (genvar i = 0; i < 3; i++) begin : g_vec
    assign raw_s[i] = {{(NIW-SumW){sum_q[i][SumW-1]}}, sum_q[i]};
    assign raw_l[i] = {{(NIW-LevelW-1){lneg[i][LevelW]}}, lneg[i]};
  end

  always_comb begin
    unique case (cmd_i.norm_src)
      SRC_SUM:   vin = raw_s;
      SRC_LIGHT: vin = raw_l;
      default:   vin = raw_c;
    endcase
  end

  hvl_nrm_t nvec, nrm_q;
  logic     norm_done;

  hvl_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.norm_start),
    .vec_i   (vin),
    .nrm_o   (nvec),
    .done_o  (norm_done)
  );

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (cmd_i.accept) begin
        sum_q[i] <= '0;
      end else if (cmd_i.sum_add) begin
        sum_q[i] <= sum_q[i] + {{(SumW-NW){nvec[i][NW-1]}}, nvec[i]};
      end
    end
    if (cmd_i.nrm_keep) begin
      nrm_q <= nvec;
    end
  end

  // shading
  logic signed [2*NW-1:0] prod;
  logic [DotW-1:0]        dot_q, prod_x, rnd;
  logic [LamW-1:0]        lam;
  logic [LevelW+LamW-1:0] plin_q;
  logic [LevelW+LamW:0]   plin_r;
  logic [LevelW+LamW-FracBits+1:0] lin;
  logic [SclW-1:0]        scaled;
  logic [GIW-1:0]         idx_q;
  logic                   sat_q;
  logic [ShadeW-1:0]      shade_q;
  logic [ShadeW-1:0]      lut [GammaEntries];

  for (genvar g = 0; g < GammaEntries; g++) begin : g_lut
    localparam logic [ShadeW-1:0] Entry = gamma_entry(g, GammaEntries);
    assign lut[g] = Entry;
  end

  assign prod   = $signed(nrm_q[cmd_i.dot_sel]) * $signed(nvec[cmd_i.dot_sel]);
  assign prod_x = {{(DotW-2*NW){prod[2*NW-1]}}, prod};
  assign rnd    = dot_q + RoundHalf;
  assign lam    = (dot_q[DotW-1] || dot_q == '0) ? '0 : rnd[FracBits +: LamW];
  assign plin_r = (LevelW+LamW+1)'(plin_q) + (LevelW+LamW+1)'(RoundHalf[FracBits-1:0]);
  assign lin    = (LevelW+LamW-FracBits+2)'(plin_r[LevelW+LamW:FracBits]) +
                  (LevelW+LamW-FracBits+2)'(amb_q);
  assign scaled = SclW'(lin[FracBits-1:0]) * SclW'(GammaEntries);

  always_ff @(posedge clk_i) begin
    if (cmd_i.dot_en) begin
      dot_q <= (cmd_i.dot_sel == 2'd0) ? prod_x : dot_q + prod_x;
    end
    if (cmd_i.lin_en) begin
      plin_q <= sun_q * lam;
    end
    if (cmd_i.gamma_en) begin
      sat_q <= lin >= (LevelW+LamW-FracBits+2)'(1 << FracBits);
      idx_q <= scaled[FracBits +: GIW];
    end
    if (cmd_i.look_en) begin
      shade_q <= sat_q ? ShadeMax : lut[idx_q];
    end
  end

  // output register
  logic              out_valid_q;
  logic [ShadeW-1:0] out_shade_q;
  logic              out_flag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_shade_q <= outside_q ? '0 : shade_q;
      out_flag_q  <= outside_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_shade_o = out_shade_q;
  assign out_flag_o  = out_flag_q;

  assign st_o.is_shade  = in_op;
  assign st_o.outside   = outside;
  assign st_o.centre    = centre_q;
  assign st_o.norm_done = norm_done;
  assign st_o.out_busy  = out_valid_q && !out_ready_i;

endmodule

// ===== rtl/heightmap_vertex_lighting.sv =====
// Channel   Dir  Fields (tdata / tuser, lowest bit first)
// s_axis    in   tdata: col[6:0] row[13:7] elevation[25:14]; tuser: operation, at_centre
// m_axis    out  tdata: shade[7:0]; tuser: out_of_grid
// cfg       in   cfg_idx_i selects register, cfg_data_i written when cfg_we_i
//
// Each vector normalization runs in the shared normalizer (3 squares, 23 root steps,
// then a divide per component), 2 times for a corner shade and 6 for a centre shade.
// Reset clears control and configuration; the elevation store is not cleared.
// A finished result waits in the output register; input is taken only when idle.
module heightmap_vertex_lighting import hvl_pkg::*; #(
  parameter int MaxTilesSide = MaxTilesSideDef,
  parameter int GammaEntries = GammaEntriesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [31:0]       s_axis_tdata,   // col, row, elevation
  input  logic [1:0]        s_axis_tuser,   // operation, at_centre
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [7:0]        m_axis_tdata,   // shade
  output logic              m_axis_tuser,   // out_of_grid
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [LevelW-1:0] cfg_data_i
);

  hvl_cmd_t    cmd;
  hvl_status_t st;

  hvl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  hvl_dp #(
    .MaxTilesSide (MaxTilesSide),
    .GammaEntries (GammaEntries)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .st_o        (st),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_shade_o (m_axis_tdata),
    .out_flag_o  (m_axis_tuser)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import hvl_pkg::*;

  localparam int GridSide = MaxTilesSideDef + 1;
  localparam int FillSide = 17;
  localparam int ShadeSpan = FillSide - 3;
  localparam int TableSize = GammaEntriesDef;
  localparam int TailCycles = 700;
  localparam longint CycleLimit = 4000000;
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_SHADE = 1'b1;
  localparam logic [2:0] CFG_UNUSED = 3'd7;

  typedef struct packed {
    logic        op;
    logic [6:0]  col;
    logic [6:0]  row;
    logic        centre;
    logic [11:0] elev;
  } hvl_item_t;

  typedef struct packed {
    logic [7:0] shade;
    logic       oog;
  } shade_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [LevelW-1:0] cfg_data_i = '0;

  heightmap_vertex_lighting dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [11:0] elev_mem [GridSide*GridSide];
  logic [7:0] gamma_lut [TableSize];
  logic [6:0] tiles_w_q = 7'd64, tiles_h_q = 7'd64;
  logic signed [14:0] lx_q = 15'sd4915, ly_q = -15'sd9830, lz_q = -15'sd13844;
  logic [14:0] sun_q = 15'd16384, amb_q = 15'd819;

  shade_res_t shade_q[$];
  int snd_idle_pct = 0, rcv_stall_pct = 0;
  int n_results = 0, n_errors = 0, n_items = 0, n_writes = 0;
  longint cycles = 0;

  function automatic bit curve_ok(int unsigned s, int unsigned k);
    logic [159:0] lhs, rhs;
    lhs = 160'd1;
    rhs = 160'd1;
    for (int i = 0; i < 11; i++) lhs = lhs * 160'(s);
    for (int i = 0; i < 5; i++) lhs = lhs * 160'(TableSize);
    for (int i = 0; i < 5; i++) rhs = rhs * 160'(k);
    for (int i = 0; i < 11; i++) rhs = rhs * 160'd255;
    return lhs <= rhs;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint div_round(longint num, longint den);
    if (num >= 0) return (num + den / 2) / den;
    return -((-num + den / 2) / den);
  endfunction

  function automatic void to_unit(input longint v[3], output longint u[3]);
    longint unsigned sq;
    longint len;
    sq = 0;
    for (int i = 0; i < 3; i++) sq += longint'(v[i] * v[i]);
    len = int_sqrt(sq);
    for (int i = 0; i < 3; i++) u[i] = (len == 0) ? 0 : div_round(v[i] * 16384, len);
  endfunction

  function automatic int clamp_side(logic [6:0] v);
    if (v < 1) return 1;
    if (v > MaxTilesSideDef) return MaxTilesSideDef;
    return v;
  endfunction

  function automatic longint height(int c, int r);
    return longint'(elev_mem[r * GridSide + c]);
  endfunction

  function automatic void vertex_normal(input int x, int y, int w, int h, output longint n[3]);
    int xl, xr, yl, yr;
    longint dxc, dyc, dzx, dzy;
    longint v[3];
    xl = (x > 0) ? x - 1 : 0;
    xr = (x + 1 < w) ? x + 1 : w;
    yl = (y > 0) ? y - 1 : 0;
    yr = (y + 1 < h) ? y + 1 : h;
    dxc = longint'(xl - xr) * 256;
    dyc = longint'(yl - yr) * 256;
    dzx = height(xl, y) - height(xr, y);
    dzy = height(x, yl) - height(x, yr);
    v[0] = -dzx * dyc;
    v[1] = -dxc * dzy;
    v[2] = dxc * dyc;
    to_unit(v, n);
  endfunction

  function automatic void predict_shade(hvl_item_t it);
    int w, h, x, y;
    longint n[3], c[3], acc[3], lv[3], su[3];
    longint dot, lam, lin;
    shade_res_t r;
    w = clamp_side(tiles_w_q);
    h = clamp_side(tiles_h_q);
    x = it.col;
    y = it.row;
    if (it.op == OP_WRITE) begin
      if (x <= w && y <= h) elev_mem[y * GridSide + x] = it.elev;
      return;
    end
    r = '0;
    if (it.centre ? (x >= w || y >= h) : (x > w || y > h)) begin
      r.oog = 1'b1;
      shade_q.push_back(r);
      return;
    end
    if (it.centre) begin
      acc = '{0, 0, 0};
      for (int k = 0; k < 4; k++) begin
        vertex_normal(x + ((k == 1 || k == 2) ? 1 : 0), y + ((k >= 2) ? 1 : 0), w, h, c);
        for (int i = 0; i < 3; i++) acc[i] += c[i];
      end
      to_unit(acc, n);
    end else vertex_normal(x, y, w, h, n);
    lv[0] = -longint'(lx_q);
    lv[1] = -longint'(ly_q);
    lv[2] = -longint'(lz_q);
    to_unit(lv, su);
    dot = n[0] * su[0] + n[1] * su[1] + n[2] * su[2];
    lam = (dot <= 0) ? 0 : (dot + 8192) >>> 14;
    lin = ((longint'(sun_q) * lam + 8192) >>> 14) + longint'(amb_q);
    r.shade = (lin >= 16384) ? 8'd255 : gamma_lut[(lin * TableSize) >>> 14];
    shade_q.push_back(r);
  endfunction

  task automatic send_item(input hvl_item_t it);
    while ($urandom_range(99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'b0, it.elev, it.row, it.col};
    s_axis_tuser <= {it.centre, it.op};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_shade(it);
    n_items++;
    if (it.op == OP_WRITE) n_writes++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (shade_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  task automatic set_reg(input logic [2:0] idx, input logic [14:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_TILES_WIDE: tiles_w_q = val[6:0];
      CFG_TILES_HIGH: tiles_h_q = val[6:0];
      CFG_LIGHT_X:    lx_q = val;
      CFG_LIGHT_Y:    ly_q = val;
      CFG_LIGHT_Z:    lz_q = val;
      CFG_SUN:        sun_q = val;
      CFG_AMBIENT:    amb_q = val;
      default: ;
    endcase
  endtask

  task automatic set_all(input logic [6:0] w, h, input logic [14:0] x, y, z, s, a);
    drain();
    set_reg(CFG_TILES_WIDE, 15'(w));
    set_reg(CFG_TILES_HIGH, 15'(h));
    set_reg(CFG_LIGHT_X, x);
    set_reg(CFG_LIGHT_Y, y);
    set_reg(CFG_LIGHT_Z, z);
    set_reg(CFG_SUN, s);
    set_reg(CFG_AMBIENT, a);
  endtask

  function automatic hvl_item_t mk(logic op, int c, int r, logic ctr, int e);
    hvl_item_t it;
    it.op = op;
    it.col = 7'(c);
    it.row = 7'(r);
    it.centre = ctr;
    it.elev = 12'(e);
    return it;
  endfunction

  // in-grid shades stay inside the filled corner of the store
  function automatic hvl_item_t rand_item();
    int w, h, cmax, rmax, cout, rout;
    hvl_item_t it;
    w = clamp_side(tiles_w_q);
    h = clamp_side(tiles_h_q);
    it.op = ($urandom_range(99) < 35) ? OP_WRITE : OP_SHADE;
    it.centre = 1'($urandom_range(1));
    if (it.op == OP_WRITE) begin
      cmax = w;
      rmax = h;
      cout = w + 1;
      rout = h + 1;
    end else begin
      cmax = it.centre ? w - 1 : w;
      rmax = it.centre ? h - 1 : h;
      cout = cmax + 1;
      rout = rmax + 1;
      if (cmax > ShadeSpan) cmax = ShadeSpan;
      if (rmax > ShadeSpan) rmax = ShadeSpan;
    end
    it.col = ($urandom_range(99) < 85) ? 7'($urandom_range(cmax)) :
                                         7'($urandom_range(127, cout));
    it.row = ($urandom_range(99) < 85) ? 7'($urandom_range(rmax)) :
                                         7'($urandom_range(127, rout));
    case ($urandom_range(9))
      0: it.elev = 12'd0;
      1: it.elev = 12'hFFF;
      default: it.elev = 12'($urandom_range(4095));
    endcase
    return it;
  endfunction

  task automatic test_fill_store();
    for (int r = 0; r < FillSide; r++)
      for (int c = 0; c < FillSide; c++)
        send_item(mk(OP_WRITE, c, r, 1'b0, int'($urandom_range(4095))));
  endtask

  task automatic test_directed_shapes();
    send_item(mk(OP_SHADE, 0, 0, 1'b0, 0));
    send_item(mk(OP_SHADE, 14, 14, 1'b0, 4095));
    send_item(mk(OP_SHADE, 0, 0, 1'b1, 0));
    send_item(mk(OP_SHADE, 14, 14, 1'b1, 0));
    send_item(mk(OP_SHADE, 65, 3, 1'b0, 0));
    send_item(mk(OP_SHADE, 3, 127, 1'b0, 0));
    send_item(mk(OP_SHADE, 64, 0, 1'b1, 0));
    send_item(mk(OP_SHADE, 0, 64, 1'b1, 0));
    send_item(mk(OP_WRITE, 127, 127, 1'b0, 4095));
    send_item(mk(OP_WRITE, 65, 0, 1'b1, 4095));
    send_item(mk(OP_SHADE, 14, 0, 1'b0, 0));
    send_item(mk(OP_WRITE, 10, 10, 1'b0, 4095));
    send_item(mk(OP_WRITE, 11, 10, 1'b0, 0));
    send_item(mk(OP_SHADE, 10, 10, 1'b0, 0));
    send_item(mk(OP_SHADE, 10, 10, 1'b1, 0));
  endtask

  task automatic test_directed_config();
    set_all(7'd0, 7'd0, 15'sd4915, -15'sd9830, -15'sd13844, 15'd16384, 15'd819);
    send_item(mk(OP_SHADE, 1, 1, 1'b0, 0));
    send_item(mk(OP_SHADE, 0, 0, 1'b1, 0));
    send_item(mk(OP_SHADE, 1, 0, 1'b1, 0));
    send_item(mk(OP_WRITE, 2, 0, 1'b0, 77));
    set_all(7'd127, 7'd127, 15'd0, 15'd0, 15'd0, 15'd16384, 15'd819);
    send_item(mk(OP_SHADE, 2, 0, 1'b0, 0));
    set_all(7'd64, 7'd64, -15'sd16384, -15'sd16384, -15'sd16384, 15'd0, 15'd16384);
    send_item(mk(OP_SHADE, 5, 5, 1'b0, 0));
    set_all(7'd64, 7'd64, 15'sd16383, 15'sd16383, -15'sd16384, 15'd16384, 15'd0);
    send_item(mk(OP_SHADE, 10, 10, 1'b0, 0));
    set_all(7'd16, 7'd16, 15'sd4915, -15'sd9830, -15'sd13844, 15'd16384, 15'd819);
    send_item(mk(OP_SHADE, 16, 16, 1'b0, 0));
    send_item(mk(OP_SHADE, 16, 0, 1'b0, 0));
    send_item(mk(OP_SHADE, 15, 15, 1'b1, 0));
    send_item(mk(OP_SHADE, 16, 3, 1'b1, 0));
    drain();
    set_reg(CFG_UNUSED, 15'h7FFF);
    send_item(mk(OP_SHADE, 13, 12, 1'b1, 0));
  endtask

  task automatic test_random_phase(input int idle, input int stall, input int count);
    logic [6:0] w, h;
    w = ($urandom_range(3) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(1, 64));
    h = ($urandom_range(3) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(1, 64));
    set_all(w, h, 15'($urandom), 15'($urandom), 15'($urandom),
            15'($urandom_range(16384)), 15'($urandom_range(8192)));
    snd_idle_pct = idle;
    rcv_stall_pct = stall;
    repeat (count) send_item(rand_item());
  endtask

  always @(posedge clk_i) m_axis_tready <= ($urandom_range(99) >= rcv_stall_pct);

  always @(posedge clk_i) begin
    shade_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (shade_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("ERROR: unexpected result shade=%0d oog=%0b",
                                     m_axis_tdata, m_axis_tuser);
      end else begin
        want = shade_q.pop_front();
        if (m_axis_tdata !== want.shade || m_axis_tuser !== want.oog) begin
          n_errors++;
          if (n_errors <= 10)
            $display("ERROR: result %0d shade exp %0d got %0d, oog exp %0b got %0b",
                     n_results, want.shade, m_axis_tdata, want.oog, m_axis_tuser);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("ERROR: timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int unsigned s;
    s = 0;
    for (int k = 0; k < TableSize; k++) begin
      while (s < 255 && curve_ok(s + 1, k)) s++;
      gamma_lut[k] = 8'(s);
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_fill_store();
    test_directed_shapes();
    test_directed_config();
    test_random_phase(0, 0, 240);
    test_random_phase(83, 0, 231);
    test_random_phase(0, 83, 231);
    test_random_phase(19, 19, 231);
    drain();
    if (shade_q.size() != 0) n_errors++;
    $display("Covered %0d transfers in (%0d elevation writes), %0d shade results checked,",
             n_items, n_writes, n_results);
    $display("over corner/centre, out-of-grid and config extremes with idle/stall mixes.");
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== heightmap_vertex_lighting.f =====
rtl/hvl_pkg.sv
rtl/hvl_ram.sv
rtl/hvl_norm.sv
rtl/hvl_ctrl.sv
rtl/hvl_dp.sv
rtl/heightmap_vertex_lighting.sv
tb/sv/tb_top.sv
